>>> design/lruc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Holds the controller/datapath command and status structs and the operation codes.
// No dependencies.
`timescale 1ns / 1ps

package lruc_pkg;

    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;
    localparam logic [WORD_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic start;
        logic cnt_clr;
        logic rd;
        logic upd;
        logic decide;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic need_upd;
    } t_sts;

endpackage

>>> design/lruc_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Sequences the scan, decision, rank update and result hand-off phases.
// Depends on lruc_pkg.
`timescale 1ns / 1ps

module lruc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  lruc_pkg::t_sts i_sts,
    output lruc_pkg::t_cmd o_cmd
);
    import lruc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_UPD,
        S_UPD_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_in_stall) begin
                    o_cmd.start   = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state       = i_sts.need_upd ? S_UPD : S_FINISH;
            end
            S_UPD: begin
                o_cmd.rd  = 1'b1;
                o_cmd.upd = 1'b1;
                if (i_sts.last) begin
                    n_state = S_UPD_DRAIN;
                end
            end
            S_UPD_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_stall = (n_state != S_IDLE);
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled after an accepted transaction.");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && (!r_out_valid || !i_out_stall)) |=> (o_out_valid && !o_in_stall))
        else $error("Finished transaction was not presented at the output.");

    a_taken_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_cmd.load_out) |=> !o_out_valid)
        else $error("Output valid held after the result was taken.");
`endif

endmodule

>>> design/lruc_dp.sv
// Datapath for the LRU key-value cache: key, data and rank memories, valid bits,
// scan accumulators, replacement decision and result registers.
// Depends on lruc_pkg.
`timescale 1ns / 1ps

module lruc_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lruc_pkg::t_cmd                i_cmd,
    output lruc_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [lruc_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_op,
    input  logic signed [lruc_pkg::WORD_W-1:0] i_key,
    input  logic signed [lruc_pkg::WORD_W-1:0] i_value,
    output logic                          o_hit,
    output logic signed [lruc_pkg::WORD_W-1:0] o_read_value,
    output logic                          o_evicted,
    output logic signed [lruc_pkg::WORD_W-1:0] o_evicted_key
);
    import lruc_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [EW-1:0] MAX_E    = EW'(MAX_ENTRIES);

    logic [WORD_W-1:0] m_key  [MAX_ENTRIES];
    logic [WORD_W-1:0] m_data [MAX_ENTRIES];
    logic [IW-1:0]     m_rank [MAX_ENTRIES];

    logic [CAP_W-1:0]       r_cap;
    logic [MAX_ENTRIES-1:0] r_valid;

    logic              r_op;
    logic [WORD_W-1:0] r_k;
    logic [WORD_W-1:0] r_v;
    logic [IW-1:0]     r_cnt;
    logic              r_pend;
    logic              r_pend_upd;
    logic [IW-1:0]     r_idx;
    logic [WORD_W-1:0] r_rd_key;
    logic [WORD_W-1:0] r_rd_data;
    logic [IW-1:0]     r_rd_rank;

    logic [CW-1:0]     r_count;
    logic              r_fnd_v;
    logic [IW-1:0]     r_fnd_i;
    logic [WORD_W-1:0] r_fnd_data;
    logic [IW-1:0]     r_fnd_rank;
    logic              r_free_v;
    logic [IW-1:0]     r_free_i;
    logic              r_vic_v;
    logic [IW-1:0]     r_vic_i;
    logic [WORD_W-1:0] r_vic_key;
    logic [IW-1:0]     r_worst;

    logic [IW-1:0]     r_tgt;
    logic [IW-1:0]     r_trank;
    logic              r_incall;

    logic              r_res_hit;
    logic [WORD_W-1:0] r_res_read;
    logic              r_res_ev;
    logic [WORD_W-1:0] r_res_ekey;

    logic              r_o_hit;
    logic [WORD_W-1:0] r_o_read;
    logic              r_o_ev;
    logic [WORD_W-1:0] r_o_ekey;

    logic [EW-1:0] cap_e;
    logic [EW-1:0] eff_cap;
    logic          room;
    logic          set_new;
    logic          set_evict;
    logic          need_upd;
    logic          kd_we;
    logic [IW-1:0] kd_addr;
    logic [IW-1:0] n_trank;
    logic          ev_pend;
    logic          rk_we;
    logic [IW-1:0] rk_new;

    always_comb begin
        cap_e = EW'(r_cap);
        if (cap_e == '0) begin
            eff_cap = EW'(1);
        end else if (cap_e > MAX_E) begin
            eff_cap = MAX_E;
        end else begin
            eff_cap = cap_e;
        end
        room      = (EW'(r_count) < eff_cap);
        set_new   = (r_op == OP_SET) && !r_fnd_v && room && r_free_v;
        set_evict = (r_op == OP_SET) && !r_fnd_v && !set_new && r_vic_v;
        need_upd  = r_fnd_v || set_new || set_evict;
        kd_we     = i_cmd.decide && (((r_op == OP_SET) && r_fnd_v) || set_new || set_evict);
        if (r_fnd_v) begin
            kd_addr = r_fnd_i;
            n_trank = r_fnd_rank;
        end else if (set_new) begin
            kd_addr = r_free_i;
            n_trank = '0;
        end else begin
            kd_addr = r_vic_i;
            n_trank = r_worst;
        end
        ev_pend = r_pend && !r_pend_upd;
        rk_we   = r_pend && r_pend_upd && (r_valid[r_idx] || (r_idx == r_tgt));
        if (r_idx == r_tgt) begin
            rk_new = '0;
        end else if (r_incall || (r_rd_rank < r_trank)) begin
            rk_new = r_rd_rank + IW'(1);
        end else begin
            rk_new = r_rd_rank;
        end
    end

    assign o_sts.last     = (r_cnt == LAST_IDX);
    assign o_sts.need_upd = need_upd;

    always_ff @(posedge i_clk) begin
        if (kd_we) begin
            m_key[kd_addr]  <= r_k;
            m_data[kd_addr] <= r_v;
        end
        if (rk_we) begin
            m_rank[r_idx] <= rk_new;
        end
        if (i_cmd.rd) begin
            r_rd_key  <= m_key[r_cnt];
            r_rd_data <= m_data[r_cnt];
            r_rd_rank <= m_rank[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAPACITY_RESET;
            r_valid    <= '0;
            r_pend     <= 1'b0;
            r_pend_upd <= 1'b0;
        end else begin
            r_pend     <= i_cmd.rd;
            r_pend_upd <= i_cmd.upd;
            if (i_cfg_we) begin
                r_cap   <= i_cfg_data;
                r_valid <= '0;
            end else if (i_cmd.decide && set_new) begin
                r_valid[r_free_i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= r_cnt;
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.rd) begin
            r_cnt <= r_cnt + IW'(1);
        end
        if (i_cmd.start) begin
            r_op     <= i_op;
            r_k      <= i_key;
            r_v      <= i_value;
            r_count  <= '0;
            r_fnd_v  <= 1'b0;
            r_free_v <= 1'b0;
            r_vic_v  <= 1'b0;
        end else if (ev_pend) begin
            if (r_valid[r_idx]) begin
                r_count <= r_count + CW'(1);
                if (r_rd_key == r_k) begin
                    r_fnd_v    <= 1'b1;
                    r_fnd_i    <= r_idx;
                    r_fnd_data <= r_rd_data;
                    r_fnd_rank <= r_rd_rank;
                end
                if (!r_vic_v || (r_rd_rank > r_worst)) begin
                    r_vic_v   <= 1'b1;
                    r_vic_i   <= r_idx;
                    r_vic_key <= r_rd_key;
                    r_worst   <= r_rd_rank;
                end
            end else if (!r_free_v) begin
                r_free_v <= 1'b1;
                r_free_i <= r_idx;
            end
        end
        if (i_cmd.decide) begin
            r_tgt      <= kd_addr;
            r_trank    <= n_trank;
            r_incall   <= set_new;
            r_res_hit  <= r_fnd_v;
            r_res_ev   <= set_evict;
            r_res_ekey <= set_evict ? r_vic_key : '0;
            if (r_op == OP_GET) begin
                r_res_read <= r_fnd_v ? r_fnd_data : MISS_VALUE;
            end else begin
                r_res_read <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_o_hit  <= r_res_hit;
            r_o_read <= r_res_read;
            r_o_ev   <= r_res_ev;
            r_o_ekey <= r_res_ekey;
        end
    end

    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_read;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_ekey;

`ifndef SYNTHESIS
    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) <= int'(eff_cap))
        else $error("More valid entries than the effective capacity.");

    a_insert_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && set_new && !i_cfg_we) |=>
            ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("Insert into a free slot did not add exactly one entry.");

    a_hit_keeps_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && r_fnd_v && !i_cfg_we) |=> (r_valid == $past(r_valid)))
        else $error("A hit changed the set of valid entries.");
`endif

endmodule

>>> design/lru_key_value_cache.sv
// Top level of the LRU key-value cache: joins the controller and the datapath.
// Depends on lruc_pkg, lruc_ctrl and lruc_dp.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_op, i_key, i_value
//   out      output     o_out_valid / i_out_stall o_hit, o_read_value, o_evicted, o_evicted_key
//   cfg      input      i_cfg_we                  i_cfg_data (capacity)
//
// A transaction is scanned one entry per cycle through the key, data and rank memories,
// then, unless it is a get miss, ranks are rewritten in a second one-entry-per-cycle sweep.
// A new input transaction is accepted while the previous result waits at the output.
// Reset is synchronous, active low; it sets capacity to 16 and empties the store at once.
// A capacity write also empties the store in the same cycle.
`timescale 1ns / 1ps

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic signed [lruc_pkg::WORD_W-1:0]  i_key,
    input  logic signed [lruc_pkg::WORD_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic signed [lruc_pkg::WORD_W-1:0]  o_read_value,
    output logic                                o_evicted,
    output logic signed [lruc_pkg::WORD_W-1:0]  o_evicted_key,
    input  logic                                i_cfg_we,
    input  logic [lruc_pkg::CAP_W-1:0]          i_cfg_data
);
    import lruc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lruc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lruc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

>>> tb/sv/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key-value cache: it drives gets and sets under random
// idling and stalls, predicts each result from its own copy of the store, and checks it.
// Depends on lruc_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

    import lruc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int ITEM_CYCLES = 2 * ENTRIES + 5;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
    } t_cache_req;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_value;
        logic              evicted;
        logic [WORD_W-1:0] evicted_key;
    } t_cache_rsp;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic                     i_op        = OP_GET;
    logic signed [WORD_W-1:0] i_key       = '0;
    logic signed [WORD_W-1:0] i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_hit;
    logic signed [WORD_W-1:0] o_read_value;
    logic                     o_evicted;
    logic signed [WORD_W-1:0] o_evicted_key;
    logic                     i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]         i_cfg_data  = CAPACITY_RESET;

    lru_key_value_cache #(
        .MAX_ENTRIES(ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [CAP_W-1:0]  mdl_capacity;
    logic              mdl_valid [ENTRIES];
    logic [WORD_W-1:0] mdl_key   [ENTRIES];
    logic [WORD_W-1:0] mdl_data  [ENTRIES];
    int unsigned       mdl_rank  [ENTRIES];

    t_cache_req pending_reqs[$];
    t_cache_rsp expected_rsps[$];
    t_cache_req next_req;
    t_cache_rsp oldest_rsp;

    int   errors        = 0;
    int   pushed_cnt    = 0;
    int   accepted_cnt  = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_tok      = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    logic in_taken      = 1'b0;

    function automatic void clear_store();
        for (int i = 0; i < ENTRIES; i++) begin
            mdl_valid[i] = 1'b0;
        end
    endfunction

    function automatic void make_recent(int slot);
        int unsigned r;
        r = mdl_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (mdl_valid[i] && mdl_rank[i] < r) begin
                mdl_rank[i]++;
            end
        end
        mdl_rank[slot] = 0;
    endfunction

    function automatic t_cache_rsp lru_access(t_cache_req req);
        t_cache_rsp  rsp;
        int          found;
        int          free_slot;
        int          victim;
        int unsigned count;
        int unsigned worst;
        int unsigned cap_eff;
        found     = -1;
        free_slot = -1;
        victim    = -1;
        count     = 0;
        worst     = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (mdl_valid[i]) begin
                count++;
                if (mdl_key[i] == req.key) begin
                    found = i;
                end
                if (victim < 0 || mdl_rank[i] > worst) begin
                    victim = i;
                    worst  = mdl_rank[i];
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        cap_eff = (mdl_capacity == 0) ? 1 :
                  ((mdl_capacity > ENTRIES) ? ENTRIES : int'(mdl_capacity));
        rsp.hit         = (found >= 0);
        rsp.read_value  = '0;
        rsp.evicted     = 1'b0;
        rsp.evicted_key = '0;
        if (req.op == OP_GET) begin
            if (found >= 0) begin
                rsp.read_value = mdl_data[found];
                make_recent(found);
            end else begin
                rsp.read_value = MISS_VALUE;
            end
        end else if (found >= 0) begin
            mdl_data[found] = req.value;
            make_recent(found);
        end else if (count < cap_eff && free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (mdl_valid[i]) begin
                    mdl_rank[i]++;
                end
            end
            mdl_valid[free_slot] = 1'b1;
            mdl_key[free_slot]   = req.key;
            mdl_data[free_slot]  = req.value;
            mdl_rank[free_slot]  = 0;
        end else if (victim >= 0) begin
            rsp.evicted     = 1'b1;
            rsp.evicted_key = mdl_key[victim];
            mdl_key[victim]  = req.key;
            mdl_data[victim] = req.value;
            make_recent(victim);
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                mdl_capacity = i_cfg_data;
                clear_store();
            end
            if (i_in_valid && !o_in_stall) begin
                expected_rsps.push_back(lru_access(t_cache_req'{i_op, i_key, i_value}));
                accepted_cnt++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected transaction", o_read_value, '0);
                end else begin
                    oldest_rsp = expected_rsps.pop_front();
                    if (o_hit !== oldest_rsp.hit)
                        report_mismatch("hit", WORD_W'(o_hit), WORD_W'(oldest_rsp.hit));
                    if (o_read_value !== oldest_rsp.read_value)
                        report_mismatch("read_value", o_read_value, oldest_rsp.read_value);
                    if (o_evicted !== oldest_rsp.evicted)
                        report_mismatch("evicted", WORD_W'(o_evicted),
                                        WORD_W'(oldest_rsp.evicted));
                    if (o_evicted_key !== oldest_rsp.evicted_key)
                        report_mismatch("evicted_key", o_evicted_key,
                                        oldest_rsp.evicted_key);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && pending_reqs.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_op       <= next_req.op;
                i_key      <= next_req.key;
                i_value    <= next_req.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_tok) begin
            hold_seen   <= hold_tok;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic push_item(logic op, logic [WORD_W-1:0] key, logic [WORD_W-1:0] value);
        pending_reqs.push_back(t_cache_req'{op, key, value});
        pushed_cnt++;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (accepted_cnt != pushed_cnt || expected_rsps.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(logic [CAP_W-1:0] cap, int n_items, bit long_hold);
        logic [WORD_W-1:0] key_pool[32];
        int                pool_n;
        int                eff;
        logic [WORD_W-1:0] k;
        eff    = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
        pool_n = eff + $urandom_range(1, 8);
        for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 11))
                0:       key_pool[i] = 32'h8000_0000;
                1:       key_pool[i] = 32'h7FFF_FFFF;
                2:       key_pool[i] = 32'hFFFF_FFFF;
                3:       key_pool[i] = 32'h0000_0000;
                default: key_pool[i] = $urandom;
            endcase
        end
        write_capacity(cap);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                if (long_hold) begin
                    hold_tok++;
                    repeat (HOLD_CYCLES + 50) @(posedge i_clk);
                end
                wait_idle();
            end
            k = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
            push_item($urandom_range(0, 1) ? OP_SET : OP_GET, k, $urandom);
        end
    endtask

    initial begin
        #5_000_000;
        $display("lru_key_value_cache_tb failed");
        $finish;
    end

    initial begin
        mdl_capacity = CAPACITY_RESET;
        clear_store();
        send_idle_pct = 10;
        recv_idle_pct = 87;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
        push_item(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        push_item(OP_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(OP_SET, 32'h8000_0000, 32'h8000_0000);
        push_item(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        push_item(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
        push_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_item(OP_GET, 32'h0000_0000, 32'h0000_0000);

        write_capacity(5'd1);
        push_item(OP_SET, 32'd5, 32'd55);
        push_item(OP_SET, 32'd6, 32'd66);
        push_item(OP_GET, 32'd5, 32'd0);
        push_item(OP_SET, 32'd6, 32'd67);
        push_item(OP_GET, 32'd6, 32'd0);

        write_capacity(5'd0);
        push_item(OP_SET, 32'd1, 32'd11);
        push_item(OP_SET, 32'd2, 32'd22);
        push_item(OP_GET, 32'd2, 32'd0);

        run_phase(5'd31, 62, 1'b0);
        run_phase(5'd16, 62, 1'b0);
        run_phase(5'd1,  62, 1'b0);

        send_idle_pct = 87;
        recv_idle_pct = 10;
        run_phase(5'd0,  62, 1'b0);
        run_phase(5'd4,  62, 1'b0);
        run_phase(5'd16, 62, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(5'd8, 62, 1'b1);
        run_phase(CAP_W'($urandom_range(0, 31)), 62, 1'b0);

        wait_idle();
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("lru_key_value_cache_tb passed");
        end else begin
            $display("lru_key_value_cache_tb failed");
        end
        $finish;
    end

endmodule
